// ===== src/tspes_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tspes_pkg
// Shared constants and types for the transport stream PES extractor.
// ----------------------------------------------------------------------------
package tspes_pkg;

    localparam int PACKET_BYTES = 188;
    localparam int POS_W        = 8;
    localparam int PID_W        = 13;
    localparam int PTS_W        = 33;
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_AW      = 2;

    localparam logic [7:0] SYNC_BYTE   = 8'h47;
    localparam logic [7:0] ADAPT_LIMIT = 8'd183;
    localparam logic [8:0] PES_POS_MAX = 9'd511;

    // classified byte handed from the front end to the PES engine
    typedef struct packed {
        logic [7:0] data;
        logic       open_pes;
    } tspes_item_t;

    typedef struct packed {
        logic [7:0]       es_byte;
        logic             first_of_pes;
        logic             pts_valid;
        logic [PTS_W-1:0] pts;
    } tspes_result_t;

endpackage

// ===== src/ts_pes_elementary_extractor_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ts_pes_elementary_extractor_unit
// Extracts the elementary stream of one PID from a packet-aligned TS.
// ----------------------------------------------------------------------------
//  channel  | signals                                  | dir
//  ---------+------------------------------------------+-----
//  input    | in_valid, in_ready, ts_byte              | in
//  result   | out_valid, out_ready, es_byte, first_of_pes, pts_valid, pts | out
//  config   | cfg_we, cfg_data (target_pid)            | in
//
// One byte per cycle sustained while the queue is not full. A kept byte enters
// the queue at the edge that accepts it; the PES engine takes it in turn once the
// output register is empty or being read, and loads that register only for bytes
// past a valid PES header. The front end counts packet positions and checks
// headers; a four-entry queue carries kept payload bytes to the PES engine, which
// holds its result in an output register. in_ready drops only when the queue is
// full. Reset clears all control state; target_pid resets to 8191.
// ----------------------------------------------------------------------------
module ts_pes_elementary_extractor_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  ts_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  es_byte,
    output logic        first_of_pes,
    output logic        pts_valid,
    output logic [32:0] pts,
    input  logic        cfg_we,
    input  logic [12:0] cfg_data
);

    logic [tspes_pkg::PID_W-1:0] pid_reg;
    logic in_fire, f_valid, q_full, q_empty, q_take;
    tspes_pkg::tspes_item_t f_item, q_item;
    tspes_pkg::tspes_result_t res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pid_reg <= 13'h1FFF;
        else if (cfg_we)
            pid_reg <= cfg_data;
    end

    assign in_ready = !q_full;
    assign in_fire  = in_valid && in_ready;

    tspes_front u_front
    (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .ts_byte(ts_byte),
        .target_pid(pid_reg), .item_valid(f_valid), .item(f_item)
    );

    tspes_fifo u_fifo
    (
        .clk(clk), .rst_n(rst_n), .wr_en(f_valid), .wr_data(f_item),
        .full(q_full), .empty(q_empty), .rd_en(q_take), .rd_data(q_item)
    );

    tspes_back u_back
    (
        .clk(clk), .rst_n(rst_n), .item_valid(!q_empty), .item(q_item),
        .item_take(q_take), .valid(out_valid), .ready(out_ready), .res(res)
    );

    assign es_byte      = res.es_byte;
    assign first_of_pes = res.first_of_pes;
    assign pts_valid    = res.pts_valid;
    assign pts          = res.pts;

    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> !in_fire) else $error("accepted into full queue");
    a_first_pts: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && pts_valid |-> first_of_pes) else $error("pts flag");
    a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> pid_reg == $past(cfg_data)) else $error("cfg write");

endmodule

// ===== src/tspes_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tspes_front
// Packet position counter and header check; forwards kept payload bytes.
// ----------------------------------------------------------------------------
module tspes_front
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_fire,
    input  logic [7:0]                     ts_byte,
    input  logic [tspes_pkg::PID_W-1:0]    target_pid,
    output logic                           item_valid,
    output tspes_pkg::tspes_item_t         item
);

    logic [tspes_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [15:0] hold_reg;
    logic        accepted_reg, accepted_next;
    logic        unit_start_reg;
    logic [7:0]  pstart_reg, pstart_next;
    logic [tspes_pkg::PID_W-1:0] pid;
    logic        hdr_ok;
    logic        fwd;

    assign pid    = {hold_reg[12:8], hold_reg[7:0]};
    // hold_reg holds bytes 1 and 2; byte 0 check folded into accepted at pos 0
    assign hdr_ok = !hold_reg[15] && pid == target_pid && ts_byte[4];

    always_comb
    begin
        pos_next      = (pos_reg == tspes_pkg::POS_W'(tspes_pkg::PACKET_BYTES - 1))
                        ? '0 : pos_reg + 1'b1;
        accepted_next = accepted_reg;
        pstart_next   = pstart_reg;
        fwd           = 1'b0;
        if (pos_reg == 8'd0)
        begin
            accepted_next = (ts_byte == tspes_pkg::SYNC_BYTE);
        end
        else if (pos_reg < 8'd3)
        begin
        end
        else if (pos_reg == 8'd3)
        begin
            accepted_next = accepted_reg && hdr_ok;
            pstart_next   = ts_byte[5] ? 8'd5 : 8'd4;
        end
        else if (pos_reg == 8'd4 && pstart_reg == 8'd5)
        begin
            if (ts_byte >= tspes_pkg::ADAPT_LIMIT)
                accepted_next = 1'b0;
            else
                pstart_next = 8'd5 + ts_byte;
        end
        else if (accepted_reg && pos_reg >= pstart_reg)
        begin
            fwd = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            accepted_reg   <= 1'b0;
            unit_start_reg <= 1'b0;
            pstart_reg     <= 8'd4;
            hold_reg       <= '0;
        end
        else if (in_fire)
        begin
            pos_reg      <= pos_next;
            accepted_reg <= accepted_next;
            pstart_reg   <= pstart_next;
            if (pos_reg == 8'd1 || pos_reg == 8'd2)
                hold_reg <= {hold_reg[7:0], ts_byte};
            if (pos_reg == 8'd3)
                unit_start_reg <= hold_reg[14];
        end
    end

    assign item_valid    = in_fire && fwd;
    assign item.data     = ts_byte;
    assign item.open_pes = (pos_reg == pstart_reg) && unit_start_reg;

endmodule

// ===== src/tspes_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tspes_fifo
// Short queue between the front end and the PES engine.
// ----------------------------------------------------------------------------
module tspes_fifo
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    wr_en,
    input  tspes_pkg::tspes_item_t  wr_data,
    output logic                    full,
    output logic                    empty,
    input  logic                    rd_en,
    output tspes_pkg::tspes_item_t  rd_data
);

    tspes_pkg::tspes_item_t mem [tspes_pkg::FIFO_DEPTH];
    logic [tspes_pkg::FIFO_AW-1:0] wp_reg, rp_reg;
    logic [tspes_pkg::FIFO_AW:0]   cnt_reg;

    assign full    = cnt_reg == (tspes_pkg::FIFO_AW+1)'(tspes_pkg::FIFO_DEPTH);
    assign empty   = cnt_reg == '0;
    assign rd_data = mem[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (wr_en)
                wp_reg <= wp_reg + 1'b1;
            if (rd_en)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (tspes_pkg::FIFO_AW+1)'(wr_en)
                               - (tspes_pkg::FIFO_AW+1)'(rd_en);
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !wr_en) else $error("fifo overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !rd_en) else $error("fifo underflow");
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && !rd_en) |=> cnt_reg == $past(cnt_reg) + 1'b1) else $error("count");

endmodule

// ===== src/tspes_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tspes_back
// PES engine: start code check, header skip, PTS capture, output register.
// ----------------------------------------------------------------------------
module tspes_back
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    input  tspes_pkg::tspes_item_t          item,
    output logic                            item_take,
    output logic                            valid,
    input  logic                            ready,
    output tspes_pkg::tspes_result_t        res
);

    logic       active_reg, good_reg, ptsok_reg, first_reg;
    logic [8:0] ppos_reg;
    logic [7:0] hlen_reg;
    logic [tspes_pkg::PTS_W-1:0] pts_reg;

    logic       active_n, good_n, ptsok_n, first_n, emit;
    logic [8:0] ppos_n, p;
    logic [7:0] hlen_n, b;
    logic [tspes_pkg::PTS_W-1:0] pts_n;
    logic       out_valid_reg;
    tspes_pkg::tspes_result_t out_reg, out_next;

    assign item_take = item_valid && (!out_valid_reg || ready);
    assign b = item.data;

    always_comb
    begin
        active_n = active_reg; good_n = good_reg; ptsok_n = ptsok_reg;
        first_n  = first_reg;  ppos_n = ppos_reg; hlen_n  = hlen_reg;
        pts_n    = pts_reg;    emit   = 1'b0;    out_next = out_reg;
        if (item.open_pes)
        begin
            active_n = 1'b1; good_n = 1'b1; ppos_n = '0; hlen_n = '0;
            pts_n = '0; ptsok_n = 1'b0; first_n = 1'b1;
        end
        p = ppos_n;
        if (active_n)
        begin
            if (p < 9'd3)
            begin
                if (b != ((p == 9'd2) ? 8'd1 : 8'd0))
                    good_n = 1'b0;
            end
            else if (p == 9'd6)
                ptsok_n = (b & 8'hC0) == 8'h80;
            else if (p == 9'd7)
            begin
                if (!b[7]) ptsok_n = 1'b0;
            end
            else if (p == 9'd8)
            begin
                hlen_n = b;
                if (b < 8'd5) ptsok_n = 1'b0;
            end
            case (p)
                9'd9:    pts_n = {b[3:1], 30'd0};
                9'd10:   pts_n[29:22] = b;
                9'd11:   pts_n[21:15] = b[7:1];
                9'd12:   pts_n[14:7]  = b;
                9'd13:   pts_n[6:0]   = b[7:1];
                default: ;
            endcase
            if (good_n && p >= 9'd9 && {1'b0, p} >= 10'd9 + {2'b0, hlen_n})
            begin
                emit = 1'b1;
                out_next.es_byte      = b;
                out_next.first_of_pes = first_n;
                out_next.pts_valid    = first_n && ptsok_n;
                out_next.pts          = (first_n && ptsok_n) ? pts_n : '0;
                first_n = 1'b0;
            end
            if (ppos_n != tspes_pkg::PES_POS_MAX)
                ppos_n = ppos_n + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0; good_reg <= 1'b0; ptsok_reg <= 1'b0;
            first_reg  <= 1'b0; ppos_reg <= '0;   hlen_reg  <= '0;
            pts_reg    <= '0;   out_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_take)
            begin
                active_reg <= active_n; good_reg <= good_n; ptsok_reg <= ptsok_n;
                first_reg  <= first_n;  ppos_reg <= ppos_n; hlen_reg  <= hlen_n;
                pts_reg    <= pts_n;
            end
            if (item_take)
                out_valid_reg <= emit || (out_valid_reg && !ready);
            else if (ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take && emit)
            out_reg <= out_next;
    end

    assign valid = out_valid_reg;
    assign res   = out_reg;

    a_pts_with_first: assert property (@(posedge clk) disable iff (!rst_n)
        valid && res.pts_valid |-> res.first_of_pes) else $error("pts without first");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !ready |=> valid && $stable(res)) else $error("result lost");
    a_pts_zero: assert property (@(posedge clk) disable iff (!rst_n)
        valid && !res.pts_valid |-> res.pts == '0) else $error("stale pts");

endmodule
